// ----- design/stable_priority_queue_core_macros.svh -----
// Assertion macros shared by the stable priority queue checker.
// No dependencies; include by bare file name.
`ifndef STABLE_PRIORITY_QUEUE_CORE_MACROS_SVH
`define STABLE_PRIORITY_QUEUE_CORE_MACROS_SVH

// Assertion on an explicit clock and active-low reset.
`define SPQ_ASSERT_CR(label, clk, rstn, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rstn) (prop)) else $error(msg);

// Assertion on the block clock and reset.
`define SPQ_ASSERT(label, prop, msg) \
  `SPQ_ASSERT_CR(label, clk_i, rst_ni, prop, msg)

`endif

// ----- design/spq_pkg.sv -----
// Shared constants and types for the stable priority queue.
// No dependencies; used by spq_cell, the top level and the checker.
package spq_pkg;

  localparam int unsigned DefaultDepth         = 16;
  localparam int unsigned DefaultValueWidth    = 32;
  localparam int unsigned DefaultPriorityWidth = 16;

  localparam int unsigned CmdWidth    = 2;
  localparam int unsigned StatusWidth = 2;

  localparam logic [CmdWidth-1:0] CmdInsert = 2'd0;
  localparam logic [CmdWidth-1:0] CmdPull   = 2'd1;
  localparam logic [CmdWidth-1:0] CmdPeek   = 2'd2;

  localparam logic [StatusWidth-1:0] StatusOk    = 2'd0;
  localparam logic [StatusWidth-1:0] StatusEmpty = 2'd1;
  localparam logic [StatusWidth-1:0] StatusFull  = 2'd2;

  // Broadcast to every cell for the request being executed.
  typedef struct packed {
    logic insert;  // insert new entry (queue not full)
    logic pull;    // remove front entry (queue not empty)
  } spq_ctrl_t;

endpackage

// ----- design/spq_cell.sv -----
// One storage cell of the sorted queue chain: a value, a priority and a valid bit.
// Depends on spq_pkg; instantiated in a row by stable_priority_queue_core.
module spq_cell #(
  parameter int unsigned VALUE_WIDTH    = spq_pkg::DefaultValueWidth,
  parameter int unsigned PRIORITY_WIDTH = spq_pkg::DefaultPriorityWidth
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  spq_pkg::spq_ctrl_t               ctrl_i,
  input  logic        [VALUE_WIDTH-1:0]    new_value_i,
  input  logic signed [PRIORITY_WIDTH-1:0] new_prio_i,
  // neighbor toward the front
  input  logic                             left_valid_i,
  input  logic        [VALUE_WIDTH-1:0]    left_value_i,
  input  logic signed [PRIORITY_WIDTH-1:0] left_prio_i,
  input  logic                             left_keep_i,
  // neighbor toward the back
  input  logic                             right_valid_i,
  input  logic        [VALUE_WIDTH-1:0]    right_value_i,
  input  logic signed [PRIORITY_WIDTH-1:0] right_prio_i,
  output logic                             valid_o,
  output logic        [VALUE_WIDTH-1:0]    value_o,
  output logic signed [PRIORITY_WIDTH-1:0] prio_o,
  output logic                             keep_o
);
  import spq_pkg::*;

  logic                             valid_q, valid_d;
  logic        [VALUE_WIDTH-1:0]    value_q, value_d;
  logic signed [PRIORITY_WIDTH-1:0] prio_q, prio_d;

  // Entry stays put on insert when it is not worse than the new one (FIFO on ties).
  assign keep_o = valid_q && (prio_q <= new_prio_i);

  always_comb begin
    valid_d = valid_q;
    value_d = value_q;
    prio_d  = prio_q;
    if (ctrl_i.insert) begin
      if (!keep_o) begin
        if (left_keep_i) begin
          valid_d = 1'b1;
          value_d = new_value_i;
          prio_d  = new_prio_i;
        end else begin
          valid_d = left_valid_i;
          value_d = left_value_i;
          prio_d  = left_prio_i;
        end
      end
    end else if (ctrl_i.pull) begin
      valid_d = right_valid_i;
      value_d = right_value_i;
      prio_d  = right_prio_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    value_q <= value_d;
    prio_q  <= prio_d;
  end

  assign valid_o = valid_q;
  assign value_o = value_q;
  assign prio_o  = prio_q;

endmodule

// ----- design/stable_priority_queue_core.sv -----
// Stable priority queue: holds up to DEPTH value/priority pairs sorted with the
// smallest priority at the front, ties served in insert order. On a request every
// cell compares its priority with the incoming one in parallel and, on an insert
// or pull, the row shifts by one place, so a request is accepted in every cycle
// that the result register is free or being drained; the result appears in the
// cycle after acceptance. Throughput is set by the single result register and its
// output handshake. There is no clearing pass after reset. Depends on spq_pkg and spq_cell.
module stable_priority_queue_core #(
  parameter int unsigned DEPTH          = spq_pkg::DefaultDepth,
  parameter int unsigned VALUE_WIDTH    = spq_pkg::DefaultValueWidth,
  parameter int unsigned PRIORITY_WIDTH = spq_pkg::DefaultPriorityWidth
) (
  input  logic                                  clk_i,
  input  logic                                  rst_ni,
  input  logic                                  s_axis_tvalid,
  output logic                                  s_axis_tready,
  // item_value, item_priority
  input  logic [((VALUE_WIDTH+PRIORITY_WIDTH+7)/8)*8-1:0] s_axis_tdata,
  // command
  input  logic [spq_pkg::CmdWidth-1:0]          s_axis_tuser,
  output logic                                  m_axis_tvalid,
  input  logic                                  m_axis_tready,
  // front_value, entry_count
  output logic [((VALUE_WIDTH+$clog2(DEPTH+1)+7)/8)*8-1:0] m_axis_tdata,
  // status
  output logic [spq_pkg::StatusWidth-1:0]       m_axis_tuser
);
  import spq_pkg::*;

  localparam int unsigned CountWidth = $clog2(DEPTH + 1);
  localparam int unsigned OutDataW   = ((VALUE_WIDTH + CountWidth + 7) / 8) * 8;

  logic                             accept;
  logic [CmdWidth-1:0]              cmd;
  logic        [VALUE_WIDTH-1:0]    new_value;
  logic signed [PRIORITY_WIDTH-1:0] new_prio;
  logic                             full, empty;
  spq_ctrl_t                        ctrl;

  logic [CountWidth-1:0] count_q, count_d;

  logic                             cell_valid [DEPTH];
  logic        [VALUE_WIDTH-1:0]    cell_value [DEPTH];
  logic signed [PRIORITY_WIDTH-1:0] cell_prio  [DEPTH];
  logic                             cell_keep  [DEPTH];

  logic                   out_valid_q;
  logic [VALUE_WIDTH-1:0] out_value_q, out_value_d;
  logic [StatusWidth-1:0] out_status_q, out_status_d;
  logic [CountWidth-1:0]  out_count_q;

  assign s_axis_tready = !out_valid_q || m_axis_tready;
  assign accept        = s_axis_tvalid && s_axis_tready;
  assign cmd           = s_axis_tuser;
  assign new_value     = s_axis_tdata[VALUE_WIDTH-1:0];
  assign new_prio      = s_axis_tdata[VALUE_WIDTH+PRIORITY_WIDTH-1:VALUE_WIDTH];

  assign full  = (count_q == CountWidth'(DEPTH));
  assign empty = (count_q == '0);

  assign ctrl.insert = accept && (cmd == CmdInsert) && !full;
  assign ctrl.pull   = accept && (cmd == CmdPull) && !empty;

  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    logic                             left_valid, right_valid, left_keep;
    logic        [VALUE_WIDTH-1:0]    left_value, right_value;
    logic signed [PRIORITY_WIDTH-1:0] left_prio, right_prio;

    if (i == 0) begin : g_front
      assign left_valid = 1'b0;
      assign left_value = '0;
      assign left_prio  = '0;
      assign left_keep  = 1'b1;
    end else begin : g_mid
      assign left_valid = cell_valid[i-1];
      assign left_value = cell_value[i-1];
      assign left_prio  = cell_prio[i-1];
      assign left_keep  = cell_keep[i-1];
    end

    if (i == DEPTH - 1) begin : g_back
      assign right_valid = 1'b0;
      assign right_value = '0;
      assign right_prio  = '0;
    end else begin : g_next
      assign right_valid = cell_valid[i+1];
      assign right_value = cell_value[i+1];
      assign right_prio  = cell_prio[i+1];
    end

    spq_cell #(
      .VALUE_WIDTH   (VALUE_WIDTH),
      .PRIORITY_WIDTH(PRIORITY_WIDTH)
    ) u_cell (
      .clk_i        (clk_i),
      .rst_ni       (rst_ni),
      .ctrl_i       (ctrl),
      .new_value_i  (new_value),
      .new_prio_i   (new_prio),
      .left_valid_i (left_valid),
      .left_value_i (left_value),
      .left_prio_i  (left_prio),
      .left_keep_i  (left_keep),
      .right_valid_i(right_valid),
      .right_value_i(right_value),
      .right_prio_i (right_prio),
      .valid_o      (cell_valid[i]),
      .value_o      (cell_value[i]),
      .prio_o       (cell_prio[i]),
      .keep_o       (cell_keep[i])
    );
  end

  always_comb begin
    count_d = count_q;
    if (ctrl.insert) begin
      count_d = count_q + CountWidth'(1);
    end else if (ctrl.pull) begin
      count_d = count_q - CountWidth'(1);
    end
  end

  always_comb begin
    out_value_d  = '0;
    out_status_d = StatusOk;
    case (cmd)
      CmdInsert: begin
        if (full) out_status_d = StatusFull;
      end
      CmdPull, CmdPeek: begin
        if (empty) begin
          out_status_d = StatusEmpty;
        end else begin
          out_value_d = cell_value[0];
        end
      end
      default: begin
        out_status_d = StatusOk;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      count_q <= count_d;
      if (accept) begin
        out_valid_q <= 1'b1;
      end else if (m_axis_tready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      out_value_q  <= out_value_d;
      out_status_q <= out_status_d;
      out_count_q  <= count_d;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = OutDataW'({out_count_q, out_value_q});
  assign m_axis_tuser  = out_status_q;

endmodule

// ----- design/spq_checker.sv -----
// Port-level checks for stable_priority_queue_core, bound to the top level.
// Depends on spq_pkg and stable_priority_queue_core_macros.svh.
`include "stable_priority_queue_core_macros.svh"

module spq_checker #(
  parameter int unsigned DEPTH          = spq_pkg::DefaultDepth,
  parameter int unsigned VALUE_WIDTH    = spq_pkg::DefaultValueWidth,
  parameter int unsigned PRIORITY_WIDTH = spq_pkg::DefaultPriorityWidth
) (
  input logic                                  clk_i,
  input logic                                  rst_ni,
  input logic                                  s_axis_tvalid,
  input logic                                  s_axis_tready,
  // item_value, item_priority
  input logic [((VALUE_WIDTH+PRIORITY_WIDTH+7)/8)*8-1:0] s_axis_tdata,
  // command
  input logic [spq_pkg::CmdWidth-1:0]          s_axis_tuser,
  input logic                                  m_axis_tvalid,
  input logic                                  m_axis_tready,
  // front_value, entry_count
  input logic [((VALUE_WIDTH+$clog2(DEPTH+1)+7)/8)*8-1:0] m_axis_tdata,
  // status
  input logic [spq_pkg::StatusWidth-1:0]       m_axis_tuser
);
  import spq_pkg::*;

  localparam int unsigned CountWidth = $clog2(DEPTH + 1);

  logic [VALUE_WIDTH-1:0] front_value;
  logic [CountWidth-1:0]  entry_count;

  assign front_value = m_axis_tdata[VALUE_WIDTH-1:0];
  assign entry_count = m_axis_tdata[VALUE_WIDTH+CountWidth-1:VALUE_WIDTH];

  `SPQ_ASSERT(a_out_hold, m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser), "result changed while stalled")

  `SPQ_ASSERT(a_no_accept_when_blocked, m_axis_tvalid && !m_axis_tready |-> !s_axis_tready, "request taken while result register blocked")

  `SPQ_ASSERT(a_empty_result, m_axis_tvalid && (m_axis_tuser == StatusEmpty) |-> (entry_count == '0) && (front_value == '0), "empty status with nonzero count or value")

  `SPQ_ASSERT(a_full_result, m_axis_tvalid && (m_axis_tuser == StatusFull) |-> (entry_count == CountWidth'(DEPTH)) && (front_value == '0), "full status with wrong count or value")

endmodule

bind stable_priority_queue_core spq_checker #(
  .DEPTH         (DEPTH),
  .VALUE_WIDTH   (VALUE_WIDTH),
  .PRIORITY_WIDTH(PRIORITY_WIDTH)
) u_spq_checker (.*);
